### rtl/ucdw_pkg.sv
package ucdw_pkg;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register indexes, taken from paddr[2].
	localparam logic REG_HID_CLASS  = 1'b0;
	localparam logic REG_PREF_PROTO = 1'b1;

	localparam logic [7:0] HID_CLASS_RESET  = 8'd3;
	localparam logic [7:0] PREF_PROTO_RESET = 8'd1;

	localparam logic [7:0] KIND_INTERFACE = 8'h04;
	localparam logic [7:0] KIND_HID       = 8'h21;
	localparam logic [7:0] KIND_ENDPOINT  = 8'h05;

	localparam logic [15:0] MIN_SET_LENGTH = 16'd9;
	localparam logic [7:0]  MIN_DESC_LENGTH = 8'd2;
	localparam logic [15:0] POS_LIMIT = 16'hFFFF;
	localparam logic [1:0]  EP_TYPE_INTERRUPT = 2'h3;
	localparam int          BODY_DEPTH = 7;

	typedef enum logic [1:0] {
		ST_PARSED     = 2'd0,
		ST_BAD_LENGTH = 2'd1,
		ST_TRUNCATED  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  if_number;
		logic [7:0]  if_class;
		logic [7:0]  if_subclass;
		logic [7:0]  if_protocol;
		logic [15:0] report_length;
		logic [7:0]  ep_address;
		logic [15:0] ep_packet_size;
		logic [7:0]  ep_poll_interval;
		logic [3:0]  ep_index;
	} kept_t;

	localparam kept_t KEPT_RESET = '{
		if_number:        8'd0,
		if_class:         8'd0,
		if_subclass:      8'd0,
		if_protocol:      8'd0,
		report_length:    16'd0,
		ep_address:       8'd0,
		ep_packet_size:   16'd8,
		ep_poll_interval: 8'd10,
		ep_index:         4'd1
	};

	typedef struct packed {
		status_t status;
		logic    interface_found;
		kept_t   kept;
	} result_t;

endpackage

### rtl/ucdw_if.sv
interface ucdw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

interface ucdw_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        interface_found;
	logic [7:0]  chosen_interface;
	logic [7:0]  chosen_class;
	logic [7:0]  chosen_subclass;
	logic [7:0]  chosen_protocol;
	logic [15:0] report_length;
	logic [7:0]  endpoint_address;
	logic [15:0] endpoint_packet_size;
	logic [7:0]  endpoint_poll_interval;
	logic [3:0]  endpoint_index;

	modport source (output valid, output status, output interface_found,
		output chosen_interface, output chosen_class, output chosen_subclass,
		output chosen_protocol, output report_length, output endpoint_address,
		output endpoint_packet_size, output endpoint_poll_interval,
		output endpoint_index, input ready);
	modport sink (input valid, input status, input interface_found,
		input chosen_interface, input chosen_class, input chosen_subclass,
		input chosen_protocol, input report_length, input endpoint_address,
		input endpoint_packet_size, input endpoint_poll_interval,
		input endpoint_index, output ready);
endinterface

### rtl/usb_config_descriptor_walker_top.sv
// Walks a USB configuration descriptor set presented one byte per item and picks one HID
// interface (a boot keyboard, by protocol, in preference), its report length and its first
// interrupt IN endpoint. The block takes one byte every cycle; a byte is registered on entry
// and, as it leaves the input register, its effect on the walk and on the kept selection is
// registered, and a last byte loads its result into the output register. Bytes keep flowing
// while a result waits in the output register; only a last byte waits for that register to be
// taken. Selections persist from one set to the next. The set length limit is MAX_SET_LENGTH.
module usb_config_descriptor_walker_top #(
	parameter int MAX_SET_LENGTH = 255
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ucdw_pkg::PADDR_W-1:0] paddr,
	input  logic [ucdw_pkg::PDATA_W-1:0] pwdata,
	output logic [ucdw_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	ucdw_in_if.sink                      descriptor,
	ucdw_out_if.source                   selection
);
	import ucdw_pkg::*;

	localparam logic [15:0] MAX_LEN = 16'(MAX_SET_LENGTH);

	// Configuration registers.
	logic [7:0] hid_class_q;
	logic [7:0] pref_proto_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// Walk state.
	logic [15:0] pos_q;
	logic [15:0] decl_q;
	logic [15:0] start_q;
	logic [7:0]  dlen_q;
	logic [7:0]  dkind_q;
	logic [7:0]  body_q [BODY_DEPTH];
	logic        stopped_q;
	logic        locked_q;
	logic        have_q;
	logic        capt_q;
	kept_t       kept_q;

	// Result register.
	logic    res_valid_q;
	result_t res_q;

	// Next-state values.
	logic [15:0] pos_d;
	logic [15:0] decl_d;
	logic [15:0] start_d;
	logic [7:0]  dlen_d;
	logic [7:0]  dkind_d;
	logic [7:0]  body_d [BODY_DEPTH];
	logic        stopped_d;
	logic        locked_d;
	logic        have_d;
	logic        capt_d;
	kept_t       kept_d;
	result_t     res_d;

	logic s1_adv;
	logic cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_HID_CLASS:  prdata = {{(PDATA_W-8){1'b0}}, hid_class_q};
			REG_PREF_PROTO: prdata = {{(PDATA_W-8){1'b0}}, pref_proto_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hid_class_q  <= HID_CLASS_RESET;
			pref_proto_q <= PREF_PROTO_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_HID_CLASS:  hid_class_q <= pwdata[7:0];
				REG_PREF_PROTO: pref_proto_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// The item in the input register moves on unless it needs the result register and that is
	// still occupied.
	assign s1_adv = valid_s1 && (!last_s1 || !res_valid_q || selection.ready);
	assign descriptor.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (descriptor.ready) begin
			valid_s1 <= descriptor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (descriptor.valid && descriptor.ready) begin
			byte_s1  <= descriptor.data_byte;
			first_s1 <= descriptor.first_byte;
			last_s1  <= descriptor.last_byte;
		end
	end

	always_comb begin
		logic        restart;
		logic [15:0] p;
		logic [15:0] diff;
		logic [16:0] next_start;
		logic [16:0] end_pos;
		logic [15:0] pos_inc;
		logic        bad;
		logic        overrun;
		logic        hid;
		logic        kbd;
		logic        header_known;

		restart   = first_s1 || (pos_q == 16'd0);
		p         = restart ? 16'd0 : pos_q;
		decl_d    = restart ? 16'd0 : decl_q;
		start_d   = restart ? 16'd0 : start_q;
		dlen_d    = restart ? 8'd0 : dlen_q;
		dkind_d   = restart ? 8'd0 : dkind_q;
		stopped_d = restart ? 1'b0 : stopped_q;
		locked_d  = restart ? 1'b0 : locked_q;
		have_d    = restart ? 1'b0 : have_q;
		capt_d    = restart ? 1'b0 : capt_q;
		body_d    = body_q;
		kept_d    = kept_q;
		diff      = p - start_d;
		next_start = '0;
		end_pos   = '0;
		overrun   = 1'b0;
		hid       = 1'b0;
		kbd       = 1'b0;

		// Header bytes: offset of the first sub-descriptor and the declared total length.
		if (p == 16'd0) begin
			start_d = {8'd0, byte_s1};
			diff    = p - start_d;
		end else if (p == 16'd2) begin
			decl_d = {8'd0, byte_s1};
		end else if (p == 16'd3) begin
			decl_d[15:8] = byte_s1;
		end
		bad = (decl_d < MIN_SET_LENGTH) || (decl_d > MAX_LEN);
		if (p == 16'd3 && bad) begin
			stopped_d = 1'b1;
		end

		if (!stopped_d && p >= start_d) begin
			if (p == start_d) begin
				dlen_d = byte_s1;
				for (int i = 0; i < BODY_DEPTH; i++) begin
					body_d[i] = 8'd0;
				end
				if (byte_s1 < MIN_DESC_LENGTH) begin
					stopped_d = 1'b1;
				end
			end else begin
				if (diff == 16'd1) begin
					dkind_d = byte_s1;
				end
				for (int i = 0; i < BODY_DEPTH; i++) begin
					if (diff == 16'(i + 2)) begin
						body_d[i] = byte_s1;
					end
				end
				next_start = {1'b0, start_d} + {9'd0, dlen_d};
				end_pos    = next_start - 17'd1;
				if ({1'b0, p} == end_pos) begin
					// A sub-descriptor that ends before byte 3 of the set has no effect.
					overrun = (p >= 16'd3) && (next_start > {1'b0, decl_d});
					if (overrun) begin
						stopped_d = 1'b1;
					end else begin
						if (p >= 16'd3) begin
							hid = body_d[3] == hid_class_q;
							kbd = hid && (body_d[5] == pref_proto_q);
							case (dkind_d)
								KIND_INTERFACE: begin
									if ((kbd && !locked_d) || (hid && !have_d)) begin
										kept_d.if_number   = body_d[0];
										kept_d.if_class    = body_d[3];
										kept_d.if_subclass = body_d[4];
										kept_d.if_protocol = body_d[5];
										kept_d.ep_index    = 4'd0;
										have_d = 1'b1;
										capt_d = 1'b1;
										if (kbd) begin
											locked_d = 1'b1;
										end
									end else begin
										capt_d = 1'b0;
									end
								end
								KIND_HID: begin
									if (capt_d) begin
										kept_d.report_length = {body_d[6], body_d[5]};
									end
								end
								KIND_ENDPOINT: begin
									if (capt_d && body_d[0][7] &&
										(body_d[1][1:0] == EP_TYPE_INTERRUPT) &&
										(kept_d.ep_index == 4'd0)) begin
										kept_d.ep_address       = body_d[0];
										kept_d.ep_packet_size   = {body_d[3], body_d[2]};
										kept_d.ep_poll_interval = body_d[4];
										kept_d.ep_index         = body_d[0][3:0];
									end
								end
								default: ;
							endcase
						end
						start_d = next_start[15:0];
					end
				end
			end
		end

		pos_inc = (p == POS_LIMIT) ? p : p + 16'd1;
		pos_d   = last_s1 ? 16'd0 : pos_inc;

		header_known = pos_inc >= 16'd4;
		if (header_known && bad) begin
			res_d.status = ST_BAD_LENGTH;
		end else if (!header_known || pos_inc < decl_d) begin
			res_d.status = ST_TRUNCATED;
		end else begin
			res_d.status = ST_PARSED;
		end
		res_d.interface_found = (res_d.status != ST_BAD_LENGTH) && have_d;
		res_d.kept = kept_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 16'd0;
			decl_q    <= 16'd0;
			start_q   <= 16'd0;
			dlen_q    <= 8'd0;
			dkind_q   <= 8'd0;
			stopped_q <= 1'b0;
			locked_q  <= 1'b0;
			have_q    <= 1'b0;
			capt_q    <= 1'b0;
			kept_q    <= KEPT_RESET;
		end else if (s1_adv) begin
			pos_q     <= pos_d;
			decl_q    <= decl_d;
			start_q   <= start_d;
			dlen_q    <= dlen_d;
			dkind_q   <= dkind_d;
			stopped_q <= stopped_d;
			locked_q  <= locked_d;
			have_q    <= have_d;
			capt_q    <= capt_d;
			kept_q    <= kept_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			body_q <= body_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (selection.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			res_q <= res_d;
		end
	end

	assign selection.valid                  = res_valid_q;
	assign selection.status                 = res_q.status;
	assign selection.interface_found        = res_q.interface_found;
	assign selection.chosen_interface       = res_q.kept.if_number;
	assign selection.chosen_class           = res_q.kept.if_class;
	assign selection.chosen_subclass        = res_q.kept.if_subclass;
	assign selection.chosen_protocol        = res_q.kept.if_protocol;
	assign selection.report_length          = res_q.kept.report_length;
	assign selection.endpoint_address       = res_q.kept.ep_address;
	assign selection.endpoint_packet_size   = res_q.kept.ep_packet_size;
	assign selection.endpoint_poll_interval = res_q.kept.ep_poll_interval;
	assign selection.endpoint_index         = res_q.kept.ep_index;

	// A new result only ever follows a last byte leaving the input register.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result raised without a last byte");

	// A locked keyboard choice implies a kept interface, and so does capturing.
	a_lock_needs_iface: assert property (@(posedge clk) disable iff (!arst_n)
		(locked_q || capt_q) |-> have_q)
		else $error("interface flags inconsistent");

	// A bad total length never reports a found interface.
	a_bad_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.interface_found && res_q.status == ST_BAD_LENGTH))
		else $error("interface reported with bad length");

	// A last byte blocked by a full result register stays in the input register unchanged.
	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && res_valid_q && !selection.ready) |=>
		(valid_s1 && last_s1 && $stable(byte_s1)))
		else $error("blocked last byte lost");

endmodule

### dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ucdw_pkg::*;

	localparam int SET_LEN_MAX = 255;
	localparam int unsigned POS_SATURATE = 65535;
	localparam int MAX_REPORTS = 10;
	localparam logic [PADDR_W-1:0] ADDR_HID_CLASS = {REG_HID_CLASS, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_PREF_PROTO = {REG_PREF_PROTO, 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ucdw_in_if desc_if ();
	ucdw_out_if result_if ();

	usb_config_descriptor_walker_top #(
		.MAX_SET_LENGTH(SET_LEN_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.descriptor(desc_if.sink),
		.selection(result_if.source)
	);

	always #4 clk = ~clk;

	// Predicted walker state, kept in step with every accepted byte.
	logic [7:0] cfg_hid_class = HID_CLASS_RESET;
	logic [7:0] cfg_pref_proto = PREF_PROTO_RESET;
	int unsigned set_pos;
	int unsigned set_total;
	int unsigned sub_start;
	int unsigned sub_len;
	logic [7:0] sub_kind;
	logic [7:0] sub_body [BODY_DEPTH];
	bit walk_halted;
	bit keyboard_held;
	bit interface_held;
	bit collecting;
	kept_t kept_sel;
	result_t expected_selections [$];

	logic [7:0] set_image [$];
	int send_gap_max = 0;
	int stall_max = 0;
	int bytes_sent = 0;
	int results_expected = 0;
	int results_checked = 0;
	int settings_applied = 0;
	int status_tally [3] = '{0, 0, 0};
	int error_count = 0;

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic void clear_walker_state();
		set_pos = 0;
		set_total = 0;
		sub_start = 0;
		sub_len = 0;
		sub_kind = '0;
		foreach (sub_body[i])
			sub_body[i] = '0;
		walk_halted = 1'b0;
		keyboard_held = 1'b0;
		interface_held = 1'b0;
		collecting = 1'b0;
		kept_sel = KEPT_RESET;
	endfunction

	function automatic bit total_out_of_range();
		return set_total < MIN_SET_LENGTH || set_total > SET_LEN_MAX;
	endfunction

	function automatic void commit_subdescriptor();
		bit is_hid;
		bit is_kbd;
		case (sub_kind)
			KIND_INTERFACE: begin
				is_hid = sub_body[3] == cfg_hid_class;
				is_kbd = is_hid && sub_body[5] == cfg_pref_proto;
				// A boot keyboard may displace the first HID interface, but only once.
				if ((is_kbd && !keyboard_held) || (is_hid && !interface_held)) begin
					kept_sel.if_number = sub_body[0];
					kept_sel.if_class = sub_body[3];
					kept_sel.if_subclass = sub_body[4];
					kept_sel.if_protocol = sub_body[5];
					kept_sel.ep_index = '0;
					interface_held = 1'b1;
					collecting = 1'b1;
					if (is_kbd)
						keyboard_held = 1'b1;
				end else begin
					collecting = 1'b0;
				end
			end
			KIND_HID: begin
				if (collecting)
					kept_sel.report_length = {sub_body[6], sub_body[5]};
			end
			KIND_ENDPOINT: begin
				if (collecting && sub_body[0][7] && sub_body[1][1:0] == EP_TYPE_INTERRUPT &&
						kept_sel.ep_index == 0) begin
					kept_sel.ep_address = sub_body[0];
					kept_sel.ep_packet_size = {sub_body[3], sub_body[2]};
					kept_sel.ep_poll_interval = sub_body[4];
					kept_sel.ep_index = sub_body[0][3:0];
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void walk_subdescriptors(int unsigned p, logic [7:0] v);
		int unsigned s;
		s = sub_start;
		if (walk_halted || p < s)
			return;
		if (p == s) begin
			sub_len = 32'(v);
			foreach (sub_body[i])
				sub_body[i] = '0;
			if (v < MIN_DESC_LENGTH)
				walk_halted = 1'b1;
			return;
		end
		if (p == s + 1)
			sub_kind = v;
		else if (p >= s + 2 && p <= s + 8)
			sub_body[3'(p - s - 2)] = v;
		if (p == s + sub_len - 1) begin
			// Sub-descriptors that end before byte 3 of the set have no effect.
			if (p >= 3) begin
				if (s + sub_len > set_total) begin
					walk_halted = 1'b1;
					return;
				end
				commit_subdescriptor();
			end
			sub_start = s + sub_len;
		end
	endfunction

	function automatic void track_descriptor_byte(logic [7:0] v, bit is_first, bit is_last);
		int unsigned p;
		bit header_known;
		result_t res;
		if (is_first || set_pos == 0) begin
			set_pos = 0;
			set_total = 0;
			sub_start = 0;
			sub_len = 0;
			sub_kind = '0;
			walk_halted = 1'b0;
			keyboard_held = 1'b0;
			interface_held = 1'b0;
			collecting = 1'b0;
		end
		p = set_pos;
		if (p == 0) begin
			sub_start = 32'(v);
		end else if (p == 2) begin
			set_total = 32'(v);
		end else if (p == 3) begin
			set_total = set_total | (int'(v) << 8);
			if (total_out_of_range())
				walk_halted = 1'b1;
		end
		walk_subdescriptors(p, v);
		if (set_pos < POS_SATURATE)
			set_pos++;
		if (!is_last)
			return;
		header_known = set_pos >= 4;
		if (header_known && total_out_of_range())
			res.status = ST_BAD_LENGTH;
		else if (!header_known || set_pos < set_total)
			res.status = ST_TRUNCATED;
		else
			res.status = ST_PARSED;
		res.interface_found = res.status != ST_BAD_LENGTH && interface_held;
		res.kept = kept_sel;
		expected_selections.push_back(res);
		results_expected++;
		status_tally[int'(res.status)]++;
		set_pos = 0;
	endfunction

	task automatic send_byte(logic [7:0] v, bit is_first, bit is_last);
		int gap;
		gap = $urandom_range(send_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			desc_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		desc_if.valid <= 1'b1;
		desc_if.data_byte <= v;
		desc_if.first_byte <= is_first;
		desc_if.last_byte <= is_last;
		do @(posedge clk); while (desc_if.ready !== 1'b1);
		track_descriptor_byte(v, is_first, is_last);
		bytes_sent++;
	endtask

	task automatic send_image(int n, bit mark_first);
		for (int i = 0; i < n; i++)
			send_byte(set_image[i], mark_first && i == 0, i == n - 1);
	endtask

	task automatic drain_results();
		@(negedge clk);
		desc_if.valid <= 1'b0;
		desc_if.first_byte <= 1'b0;
		desc_if.last_byte <= 1'b0;
		while (expected_selections.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(logic [PADDR_W-1:0] addr, logic [7:0] want);
		logic [PDATA_W-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== PDATA_W'(want))
			flag_error($sformatf("register read at 0x%0h: expected 0x%0h, got 0x%0h",
				addr, want, got));
	endtask

	task automatic set_selection_policy(logic [7:0] hid_class, logic [7:0] pref_proto);
		drain_results();
		apb_write(ADDR_HID_CLASS, PDATA_W'(hid_class));
		apb_write(ADDR_PREF_PROTO, PDATA_W'(pref_proto));
		apb_read_check(ADDR_HID_CLASS, hid_class);
		apb_read_check(ADDR_PREF_PROTO, pref_proto);
		cfg_hid_class = hid_class;
		cfg_pref_proto = pref_proto;
		settings_applied++;
	endtask

	function automatic void add_subdescriptor();
		logic [7:0] f [BODY_DEPTH];
		logic [7:0] len;
		logic [7:0] kind;
		int pick;
		foreach (f[i])
			f[i] = 8'($urandom);
		pick = $urandom_range(9);
		if (pick <= 2) begin
			kind = KIND_INTERFACE;
			len = 8'd9;
			f[3] = ($urandom_range(3) != 0) ? cfg_hid_class : 8'($urandom);
			case ($urandom_range(3))
				0, 1: f[5] = cfg_pref_proto;
				2: f[5] = 8'($urandom_range(2));
				default: ;
			endcase
		end else if (pick <= 4) begin
			kind = KIND_HID;
			len = 8'd9;
		end else if (pick <= 7) begin
			kind = KIND_ENDPOINT;
			len = 8'd7;
			if ($urandom_range(4) != 0)
				f[0][7] = 1'b1;
			if ($urandom_range(3) != 0)
				f[1][1:0] = EP_TYPE_INTERRUPT;
		end else begin
			kind = 8'($urandom);
			len = 8'($urandom_range(12, 2));
		end
		// Now and then a length that cuts the body short, pads it or halts the walk.
		case ($urandom_range(15))
			0: len = 8'($urandom_range(8, 2));
			1: len = 8'($urandom_range(14, 10));
			2: len = 8'($urandom_range(1));
			default: ;
		endcase
		set_image.push_back(len);
		set_image.push_back(kind);
		for (int i = 0; i < int'(len) - 2; i++)
			set_image.push_back(i < BODY_DEPTH ? f[i] : 8'($urandom));
	endfunction

	function automatic void build_set();
		logic [7:0] lead;
		lead = ($urandom_range(7) == 0) ? 8'($urandom_range(12)) : 8'd9;
		set_image.delete();
		set_image.push_back(lead);
		set_image.push_back(8'h02);
		set_image.push_back(8'h00);
		set_image.push_back(8'h00);
		repeat (5) set_image.push_back(8'($urandom));
		repeat ($urandom_range(6, 1)) begin
			if (set_image.size() < 220)
				add_subdescriptor();
		end
	endfunction

	task automatic run_random_set();
		int unsigned total;
		int variant;
		int n;
		int cut;
		bit mark_first;
		send_gap_max = ($urandom_range(9) < 3) ? 0 : 8;
		stall_max = ($urandom_range(9) < 3) ? 0 : 8;
		build_set();
		total = set_image.size();
		variant = $urandom_range(99);
		if (variant < 8)
			total = total - $urandom_range(8, 1);
		else if (variant < 15)
			total = $urandom_range(1) ? $urandom_range(8) : $urandom_range(65535, 256);
		set_image[2] = total[7:0];
		set_image[3] = total[15:8];
		if (variant >= 15 && variant < 22)
			repeat ($urandom_range(5, 1)) set_image.push_back(8'($urandom));
		if (variant >= 34 && variant < 39) begin
			set_image.delete();
			repeat ($urandom_range(20, 1)) set_image.push_back(8'($urandom));
		end
		n = set_image.size();
		if (variant >= 22 && variant < 30)
			n = $urandom_range(n - 1, 1);
		if (variant >= 30 && variant < 34) begin
			// An abandoned prefix, then the whole set again behind a restart mark.
			cut = $urandom_range(n - 1, 1);
			for (int i = 0; i < cut; i++)
				send_byte(set_image[i], i == 0, 1'b0);
			mark_first = 1'b1;
		end else begin
			mark_first = $urandom_range(3) != 0;
		end
		send_image(n, mark_first);
	endtask

	task automatic test_header_cases();
		send_gap_max = 0;
		stall_max = 0;
		set_image = {8'hFF};
		send_image(1, 1'b1);
		set_image = {8'd9, 8'h02, 8'd8, 8'h00};
		send_image(4, 1'b0);
		// The walk starts inside the header, and the total is one past the maximum.
		set_image = {8'd1, 8'h02, 8'h00, 8'h01};
		send_image(4, 1'b1);
		set_image = {8'd1, 8'h02, 8'd9, 8'h00, 8'h02, 8'hFF, 8'h03, 8'hAA, 8'h55, 8'hFF};
		send_image(10, 1'b1);
		set_image = {8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
		send_image(5, 1'b1);
		drain_results();
	endtask

	task automatic test_register_access();
		set_selection_policy(8'h00, 8'hFF);
		set_selection_policy(8'hFF, 8'h00);
		set_selection_policy(HID_CLASS_RESET, PREF_PROTO_RESET);
	endtask

	task automatic test_selection_random();
		int phase_bytes;
		int phase_results;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_selection_policy(HID_CLASS_RESET, PREF_PROTO_RESET);
				1: set_selection_policy(8'h00, 8'h00);
				2: set_selection_policy(8'hFF, 8'hFF);
				3, 4: set_selection_policy(8'($urandom), 8'($urandom));
				default: set_selection_policy(HID_CLASS_RESET, 8'h02);
			endcase
			phase_bytes = bytes_sent;
			phase_results = results_expected;
			while (bytes_sent - phase_bytes < 200 || results_expected - phase_results < 4)
				run_random_set();
		end
		drain_results();
	endtask

	initial begin : result_sink
		int stall;
		result_if.ready = 1'b0;
		forever begin
			stall = $urandom_range(stall_max);
			@(negedge clk);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (result_if.valid !== 1'b1);
		end
	end

	function automatic void compare_field(string field, logic [15:0] want_v,
			logic [15:0] got_v);
		if (got_v !== want_v)
			flag_error($sformatf("result %0d, %s: expected 0x%0h, got 0x%0h",
				results_checked, field, want_v, got_v));
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			if (expected_selections.size() == 0) begin
				flag_error("result arrived with nothing expected");
			end else begin
				want = expected_selections.pop_front();
				compare_field("status", 16'(want.status), 16'(result_if.status));
				compare_field("interface_found", 16'(want.interface_found),
					16'(result_if.interface_found));
				compare_field("chosen_interface", 16'(want.kept.if_number),
					16'(result_if.chosen_interface));
				compare_field("chosen_class", 16'(want.kept.if_class),
					16'(result_if.chosen_class));
				compare_field("chosen_subclass", 16'(want.kept.if_subclass),
					16'(result_if.chosen_subclass));
				compare_field("chosen_protocol", 16'(want.kept.if_protocol),
					16'(result_if.chosen_protocol));
				compare_field("report_length", want.kept.report_length,
					result_if.report_length);
				compare_field("endpoint_address", 16'(want.kept.ep_address),
					16'(result_if.endpoint_address));
				compare_field("endpoint_packet_size", want.kept.ep_packet_size,
					result_if.endpoint_packet_size);
				compare_field("endpoint_poll_interval", 16'(want.kept.ep_poll_interval),
					16'(result_if.endpoint_poll_interval));
				compare_field("endpoint_index", 16'(want.kept.ep_index),
					16'(result_if.endpoint_index));
				results_checked++;
			end
		end
	end

	initial begin : watchdog
		#4ms;
		$display("Timeout: the run did not finish in time");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : run_tests
		desc_if.valid = 1'b0;
		desc_if.data_byte = '0;
		desc_if.first_byte = 1'b0;
		desc_if.last_byte = 1'b0;
		clear_walker_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_header_cases();
		test_register_access();
		test_selection_random();

		@(negedge clk);
		desc_if.valid <= 1'b0;
		for (int i = 0; i < 5000 && expected_selections.size() != 0; i++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_selections.size() != 0)
			flag_error($sformatf("%0d expected results never arrived",
				expected_selections.size()));

		$display("Sent %0d descriptor bytes; checked %0d results", bytes_sent,
			results_checked);
		$display("(%0d parsed, %0d bad length, %0d truncated); selection registers set %0d times.",
			status_tally[0], status_tally[1], status_tally[2], settings_applied);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
